// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define ASSERT_HOLD(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// A condition that implies another in the same cycle.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_HOLD(label, clk_s, rst_s, prop, msg)
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg)
`endif

`endif

// ===== design/md4_pkg.sv =====
// ----------------------------------------------------------------------------
// MD4 package
// Constants, state codes and round helper functions of the MD4 engine.
// ----------------------------------------------------------------------------
package md4_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] K2  = 32'h5a827999;
  localparam logic [31:0] K3  = 32'h6ed9eba1;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_RND  = 6'd47;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_FINAL = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  // Where the sequencer goes once a compression has finished.
  typedef enum logic [1:0] {
    RET_IDLE = 2'd0,
    RET_PAD  = 2'd1,
    RET_OUT  = 2'd2
  } ret_t;

  // Message word order: straight, 4x4 transposed, then bit-reversed.
  function automatic logic [3:0] word_index(input logic [5:0] rnd);
    logic [3:0] j;
    logic [3:0] idx;
    j = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = j;
      2'd1:    idx = {j[1:0], j[3:2]};
      default: idx = {j[0], j[1], j[2], j[3]};
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'b0000: s = 5'd3;
      4'b0001: s = 5'd7;
      4'b0010: s = 5'd11;
      4'b0011: s = 5'd19;
      4'b0100: s = 5'd3;
      4'b0101: s = 5'd5;
      4'b0110: s = 5'd9;
      4'b0111: s = 5'd13;
      4'b1000: s = 5'd3;
      4'b1001: s = 5'd9;
      4'b1010: s = 5'd11;
      default: s = 5'd15;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] round_const(input logic [1:0] grp);
    logic [31:0] k;
    case (grp)
      2'd0:    k = 32'd0;
      2'd1:    k = K2;
      default: k = K3;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] tmp;
    tmp = {v, v} << s;
    return tmp[63:32];
  endfunction

endpackage

// ===== design/md4_if.sv =====
// ----------------------------------------------------------------------------
// MD4 channel interfaces
// Valid/ready channels for message items and for digest results.
// ----------------------------------------------------------------------------
interface md4_msg_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface md4_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source (output valid, output digest_a, output digest_b, output digest_c,
                  output digest_d, input ready);
  modport sink (input valid, input digest_a, input digest_b, input digest_c,
                input digest_d, output ready);
endinterface

// ===== design/md4_hash_engine.sv =====
// ----------------------------------------------------------------------------
// MD4 hash engine
// Byte-serial MD4 digest with one shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The msg channel carries one item per transfer: cmd 0 absorbs data_byte,
// cmd 1 finishes the message. A finish yields one transfer on the digest
// channel with the four chaining words; the engine then restarts from the
// initial vector with a zero bit count.
// Timing: msg.ready is high only while the sequencer is idle. A byte that
// does not complete a block leaves the sequencer idle. The byte that
// completes a block starts a compression: 48 rounds through the single
// round adder/rotator, then the chaining add.
// A finish at fill level f (bytes already in the block) holds msg.ready low
// while the sequencer writes zero pad bytes up to byte 56 (when f is at most
// 55) and the 8 length bytes, runs the compression and loads the digest
// register. When the pad mark leaves no room for the length, that block is
// compressed first and a second block is padded from byte 0.
// The digest is registered; its transfer may overlap the next item.
// If a second digest is ready while the first is still stalled, the engine
// waits before releasing it and accepts no item meanwhile.
// Reset (synchronous, rst high) restores the initial vector and a zero
// count and drops any pending digest. Block bytes need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md4_hash_engine
  import md4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  md4_msg_if.sink      msg,
  md4_digest_if.source digest
);

  state_t      state;
  ret_t        ret;
  logic [31:0] chain [4];
  logic [63:0] bit_total;
  logic [5:0]  ptr;
  logic [5:0]  rnd;
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] words [16];
  logic        out_valid;
  logic [31:0] out_a, out_b, out_c, out_d;

  logic [5:0]  fill;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  logic [31:0] w_cur;
  logic [31:0] round_sum;
  logic [31:0] round_t;
  logic [31:0] sum_a, sum_b, sum_c, sum_d;

  assign fill = bit_total[8:3];
  assign msg.ready = (state == S_IDLE);

  assign digest.valid    = out_valid;
  assign digest.digest_a = out_a;
  assign digest.digest_b = out_b;
  assign digest.digest_c = out_c;
  assign digest.digest_d = out_d;

  // Single byte write port into the block buffer.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_byte = 8'h00;
    unique case (state)
      S_IDLE: begin
        wr_en   = msg.valid;
        wr_addr = fill;
        wr_byte = msg.cmd ? PAD_MARK : msg.data_byte;
      end
      S_PAD: begin
        wr_en = (ptr != LEN_POS);
      end
      S_LEN: begin
        wr_en   = 1'b1;
        wr_byte = bit_total[{ptr[2:0], 3'b000} +: 8];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  // Shared round unit: one MD4 step per cycle.
  always_comb begin
    w_cur     = words[word_index(rnd)];
    round_sum = wa + round_fn(rnd[5:4], wb, wc, wd) + w_cur + round_const(rnd[5:4]);
    round_t   = rotl(round_sum, rot_amount(rnd));
    sum_a     = chain[0] + wa;
    sum_b     = chain[1] + wb;
    sum_c     = chain[2] + wc;
    sum_d     = chain[3] + wd;
  end

  // Working registers follow the chaining words until a compression starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= 6'd0;
    end else if (state == S_ROUND) begin
      rnd <= rnd + 6'd1;
    end else begin
      rnd <= 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ROUND) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= round_t;
    end else begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= RET_IDLE;
      chain[0]  <= IV0;
      chain[1]  <= IV1;
      chain[2]  <= IV2;
      chain[3]  <= IV3;
      bit_total <= 64'd0;
      ptr       <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      // The hold state decides the output register on its own.
      if (digest.valid && digest.ready && state != S_HOLD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (msg.valid) begin
            if (!msg.cmd) begin
              bit_total <= bit_total + 64'd8;
              if (fill == LAST_BYTE) begin
                state <= S_ROUND;
                ret   <= RET_IDLE;
              end
            end else begin
              ptr <= fill + 6'd1;
              if (fill == LAST_BYTE) begin
                state <= S_ROUND;
                ret   <= RET_PAD;
              end else begin
                state <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          if (ptr == LEN_POS) begin
            state <= S_LEN;
          end else begin
            ptr <= ptr + 6'd1;
            // The pad mark left no room for the length: close this block first.
            if (ptr == LAST_BYTE) begin
              state <= S_ROUND;
              ret   <= RET_PAD;
            end
          end
        end
        S_LEN: begin
          ptr <= ptr + 6'd1;
          if (ptr == LAST_BYTE) begin
            state <= S_ROUND;
            ret   <= RET_OUT;
          end
        end
        S_ROUND: begin
          if (rnd == LAST_RND) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          chain[0] <= sum_a;
          chain[1] <= sum_b;
          chain[2] <= sum_c;
          chain[3] <= sum_d;
          if (ret == RET_OUT) begin
            state <= S_HOLD;
          end else begin
            state <= (ret == RET_PAD) ? S_PAD : S_IDLE;
          end
        end
        S_HOLD: begin
          // Release the digest once the output register is free.
          if (!out_valid || digest.ready) begin
            out_a     <= chain[0];
            out_b     <= chain[1];
            out_c     <= chain[2];
            out_d     <= chain[3];
            out_valid <= 1'b1;
            chain[0]  <= IV0;
            chain[1]  <= IV1;
            chain[2]  <= IV2;
            chain[3]  <= IV3;
            bit_total <= 64'd0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_rnd_range, clk, rst, state == S_ROUND, rnd <= LAST_RND, "round count overran")
  `ASSERT_IMPL(a_len_ptr, clk, rst, state == S_LEN, ptr[5:3] == 3'b111, "length byte outside tail")
  `ASSERT_HOLD(a_digest_src, clk, rst, $rose(digest.valid) |-> $past(state == S_HOLD), "digest from wrong state")
  `ASSERT_HOLD(a_count_clear, clk, rst, $rose(digest.valid) |-> (bit_total == 64'd0), "bit count not cleared")

endmodule
